@@ rtl/goi_pkg.sv @@
// Shared types, constants and tables for the gyro orientation integrator.
package goi_pkg;

    localparam logic [31:0] TS_RESET    = 32'd4294967;
    localparam logic [31:0] INV_4PI_Q32 = 32'd341782638;
    localparam logic [31:0] TWO_PI_Q29  = 32'd3373259426;
    localparam logic [15:0] QP_NEG_MASK = 16'h428E;

    typedef enum logic [5:0] {
        ST_SQ_MUL, ST_SQ_ACC, ST_LEN_SQRT, ST_LEN_SAVE, ST_P_MUL, ST_P_CHK,
        ST_PH_MUL_H, ST_PH_SAVE_H, ST_PH_MUL_L, ST_PH_SAVE_L, ST_A_MUL, ST_A_SAVE,
        ST_X2_MUL, ST_X2_SAVE, ST_H_MUL, ST_H_DIV, ST_H_SAVE, ST_SN_MUL, ST_SN_SAVE,
        ST_CS_SAVE, ST_DV_MUL, ST_DV_DIV, ST_DV_SAVE, ST_QP_MUL, ST_QP_ACC,
        ST_QP_SAVE, ST_NQ_MUL, ST_NQ_ACC, ST_N_SQRT, ST_N_SAVE, ST_Q_DIV,
        ST_Q_SAVE, ST_Q_ZERO
    } t_step;

    typedef struct packed {
        logic       capture;
        logic       go;
        logic       out_load;
        t_step      step;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic unit_done;
        logic prod_zero;
        logic root_zero;
    } t_stat;

    typedef struct packed {
        logic [1:0]  pre;
        logic [5:0]  post;
        logic [31:0] mult;
    } t_recip;

    // Taylor divisors as reciprocals, sine terms first, then cosine terms:
    // n / divisor = ((n >> pre) * mult) >> post, exact for n below 2^30
    function automatic t_recip horner_recip(input logic [3:0] idx);
        t_recip r;
        unique case (idx)
            4'd0:    r = '{2'd3, 6'd33, 32'd954437177};  // 72
            4'd1:    r = '{2'd1, 6'd34, 32'd818089009};  // 42
            4'd2:    r = '{2'd2, 6'd32, 32'd858993460};  // 20
            4'd3:    r = '{2'd1, 6'd31, 32'd715827883};  // 6
            4'd4:    r = '{2'd1, 6'd35, 32'd763549742};  // 90
            4'd5:    r = '{2'd3, 6'd32, 32'd613566757};  // 56
            4'd6:    r = '{2'd1, 6'd33, 32'd572662307};  // 30
            4'd7:    r = '{2'd2, 6'd31, 32'd715827883};  // 12
            default: r = '{2'd1, 6'd29, 32'd536870912};  // 2
        endcase
        return r;
    endfunction

    function automatic logic is_unit_step(input t_step s);
        return (s == ST_LEN_SQRT) || (s == ST_N_SQRT) ||
               (s == ST_DV_DIV) || (s == ST_Q_DIV);
    endfunction

    function automatic logic is_mul_step(input t_step s);
        return (s == ST_SQ_MUL) || (s == ST_P_MUL) || (s == ST_PH_MUL_H) ||
               (s == ST_PH_MUL_L) || (s == ST_A_MUL) || (s == ST_X2_MUL) ||
               (s == ST_H_MUL) || (s == ST_H_DIV) || (s == ST_SN_MUL) ||
               (s == ST_DV_MUL) || (s == ST_QP_MUL) || (s == ST_NQ_MUL);
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

endpackage

@@ rtl/goi_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module goi_sqrt
    import goi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root,
    output logic        o_done
);
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [35:0] w_rem2;
    logic [35:0] w_trial;
    logic        w_fit;

    assign w_rem2  = {r_rem, r_rad[63:62]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_fit   = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_rad;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rad  <= {r_rad[61:0], 2'b00};
                r_rem  <= w_fit ? 34'(w_rem2 - w_trial) : w_rem2[33:0];
                r_root <= {r_root[30:0], w_fit};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
    assign o_done = r_done;
endmodule

@@ rtl/goi_div.sv @@
// Iterative unsigned divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
module goi_div
    import goi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [31:0] i_den,
    output logic [63:0] o_quot,
    output logic        o_done
);
    logic [63:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_rem2;
    logic        w_fit;

    assign w_rem2 = {r_rem, r_num[63]};
    assign w_fit  = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[62:0], w_fit};
                r_rem <= w_fit ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_num;
    assign o_done = r_done;
endmodule

@@ rtl/goi_datapath.sv @@
// Datapath: orientation, working registers, shared multiplier, sqrt and divide units.
module goi_datapath
    import goi_pkg::*;
#(
    parameter int FRAC_BITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cmd         i_cmd,
    output t_stat        o_stat,
    input  logic [223:0] i_tdata,
    input  logic         i_func,
    input  logic         i_cfg_wen,
    input  logic [31:0]  i_cfg_wdata,
    output logic [127:0] o_tdata,
    output logic         o_rot
);
    localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

    logic [31:0] r_ts;
    logic [31:0] r_q [4];
    logic [31:0] r_v [3];
    logic [31:0] r_d [4];
    logic [32:0] r_m [4];
    logic [63:0] r_prod;
    logic        r_pneg;
    logic [63:0] r_sum;
    logic [65:0] r_acc;
    logic [31:0] r_len;
    logic [31:0] r_n;
    logic [47:0] r_t48;
    logic [31:0] r_phase;
    logic [31:0] r_x;
    logic [31:0] r_x2;
    logic [31:0] r_t;
    logic [31:0] r_sn;
    logic [31:0] r_sin;
    logic        r_rot;
    logic [127:0] r_out_data;
    logic         r_out_rot;

    logic [1:0]  w_i;
    logic [1:0]  w_j;
    logic [1:0]  w_b;
    logic [2:0]  w_oct;
    logic [31:0] w_a;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic        w_neg;
    logic [31:0] w_mmag;
    logic [63:0] w_num;
    logic [31:0] w_den;
    logic [63:0] w_quot;
    logic [31:0] w_root;
    logic        w_sq_done;
    logic        w_div_done;
    logic        w_sq_start;
    logic        w_div_start;
    logic [65:0] w_term;
    logic [65:0] w_accmag;
    logic [31:0] w_msh;
    logic [31:0] w_sn;
    logic [31:0] w_cs;
    logic [31:0] w_qsat;
    t_recip      w_recip;

    assign w_i   = i_cmd.idx[1:0];
    assign w_j   = i_cmd.idx[1:0];
    assign w_b   = i_cmd.idx[3:2] ^ i_cmd.idx[1:0];
    assign w_oct = r_phase[31:29];
    assign w_a   = w_oct[0] ? (32'h2000_0000 - {3'b000, r_phase[28:0]})
                            : {3'b000, r_phase[28:0]};
    assign w_mmag = r_m[w_i][32] ? 32'(~r_m[w_i] + 33'd1) : r_m[w_i][31:0];
    assign w_recip = horner_recip(i_cmd.idx);

    always_comb begin
        w_ma  = r_x;
        w_mb  = r_x;
        w_neg = 1'b0;
        unique case (i_cmd.step)
            ST_SQ_MUL:   begin w_ma = mag32(r_v[w_i]); w_mb = mag32(r_v[w_i]); end
            ST_P_MUL:    begin w_ma = r_len; w_mb = r_ts; end
            ST_PH_MUL_H: begin w_ma = {16'd0, r_t48[47:32]}; w_mb = INV_4PI_Q32; end
            ST_PH_MUL_L: begin w_ma = r_t48[31:0]; w_mb = INV_4PI_Q32; end
            ST_A_MUL:    begin w_ma = w_a; w_mb = TWO_PI_Q29; end
            ST_H_MUL:    begin w_ma = r_x2; w_mb = r_t; end
            ST_H_DIV:    begin
                w_ma = 32'(r_prod >> (FRAC_BITS + w_recip.pre));
                w_mb = w_recip.mult;
            end
            ST_SN_MUL:   begin w_ma = r_x; w_mb = r_t; end
            ST_DV_MUL:   begin w_ma = mag32(r_v[w_i]); w_mb = mag32(r_sin); end
            ST_QP_MUL:   begin
                w_ma  = mag32(r_d[w_j]);
                w_mb  = mag32(r_q[w_b]);
                w_neg = r_d[w_j][31] ^ r_q[w_b][31] ^ QP_NEG_MASK[i_cmd.idx];
            end
            ST_NQ_MUL:   begin w_ma = w_mmag; w_mb = w_mmag; end
            default:     begin w_ma = r_x; w_mb = r_x; end
        endcase
    end

    always_comb begin
        unique case (i_cmd.step)
            ST_Q_DIV: begin
                w_num = {32'd0, w_mmag} << FRAC_BITS;
                w_den = r_n;
            end
            default: begin
                w_num = r_prod;
                w_den = r_len;
            end
        endcase
    end

    assign w_sq_start  = i_cmd.go && ((i_cmd.step == ST_LEN_SQRT) || (i_cmd.step == ST_N_SQRT));
    assign w_div_start = i_cmd.go && ((i_cmd.step == ST_DV_DIV) || (i_cmd.step == ST_Q_DIV));

    goi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (r_sum),
        .o_root  (w_root),
        .o_done  (w_sq_done)
    );

    goi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    assign w_term   = r_pneg ? (~{2'b00, r_prod} + 66'd1) : {2'b00, r_prod};
    assign w_accmag = r_acc[65] ? (~r_acc + 66'd1) : r_acc;
    assign w_msh    = 32'(w_accmag >> (FRAC_BITS + 2));

    // octant fold: swap for octants 1,2,5,6
    assign w_sn = (w_oct[1] ^ w_oct[0]) ? r_t : r_sn;
    assign w_cs = (w_oct[1] ^ w_oct[0]) ? r_sn : r_t;

    always_comb begin
        if (r_m[w_i][32]) begin
            w_qsat = (w_quot > 64'h8000_0000) ? 32'h8000_0000 : (~w_quot[31:0] + 32'd1);
        end else begin
            w_qsat = (w_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : w_quot[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts  <= TS_RESET;
            r_q   <= '{ONE, 32'd0, 32'd0, 32'd0};
            r_rot <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_ts <= i_cfg_wdata;
            end
            if (i_cmd.capture) begin
                r_v   <= '{i_tdata[31:0], i_tdata[63:32], i_tdata[95:64]};
                r_rot <= 1'b0;
                if (i_func) begin
                    r_q <= '{i_tdata[127:96], i_tdata[159:128], i_tdata[191:160],
                             i_tdata[223:192]};
                end
            end
            if (i_cmd.go && is_mul_step(i_cmd.step)) begin
                r_prod <= 64'(w_ma) * 64'(w_mb);
                r_pneg <= w_neg;
            end
            if (i_cmd.go) begin
                unique case (i_cmd.step)
                    ST_SQ_ACC, ST_NQ_ACC: r_sum <= (w_i == 2'd0) ? r_prod : r_sum + r_prod;
                    ST_LEN_SAVE:  r_len   <= w_root;
                    ST_P_CHK:     r_t48   <= r_prod[63:16];
                    ST_PH_SAVE_H: r_phase <= r_prod[31:0];
                    ST_PH_SAVE_L: r_phase <= r_phase + r_prod[63:32];
                    ST_A_SAVE:    r_x     <= 32'(r_prod >> (61 - FRAC_BITS));
                    ST_X2_SAVE: begin
                        r_x2 <= 32'(r_prod >> FRAC_BITS);
                        r_t  <= ONE;
                    end
                    ST_H_SAVE:    r_t <= ONE - 32'(r_prod >> w_recip.post);
                    ST_SN_SAVE: begin
                        r_sn <= 32'(r_prod >> FRAC_BITS);
                        r_t  <= ONE;
                    end
                    ST_CS_SAVE: begin
                        r_sin  <= w_oct[2] ? (~w_sn + 32'd1) : w_sn;
                        r_d[0] <= (w_oct[2] ^ w_oct[1]) ? (~w_cs + 32'd1) : w_cs;
                    end
                    ST_DV_SAVE:
                        r_d[w_i + 2'd1] <= (r_v[w_i][31] ^ r_sin[31]) ?
                                           (~w_quot[31:0] + 32'd1) : w_quot[31:0];
                    ST_QP_ACC:
                        r_acc <= ((w_j == 2'd0) ? 66'd0 : r_acc) + w_term;
                    ST_QP_SAVE:
                        r_m[i_cmd.idx[3:2]] <= r_acc[65] ? (~{1'b0, w_msh} + 33'd1)
                                                         : {1'b0, w_msh};
                    ST_N_SAVE:    r_n <= w_root;
                    ST_Q_SAVE: begin
                        r_q[w_i] <= w_qsat;
                        r_rot    <= 1'b1;
                    end
                    ST_Q_ZERO: begin
                        r_q   <= '{32'd0, 32'd0, 32'd0, 32'd0};
                        r_rot <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_data <= {r_q[3], r_q[2], r_q[1], r_q[0]};
                r_out_rot  <= r_rot;
            end
        end
    end

    assign o_stat.unit_done = w_sq_done | w_div_done;
    assign o_stat.prod_zero = (r_prod == 64'd0);
    assign o_stat.root_zero = (w_root == 32'd0);
    assign o_tdata = r_out_data;
    assign o_rot   = r_out_rot;
endmodule

@@ rtl/goi_ctrl.sv @@
// Controller: sequences datapath steps and handles both stream handshakes.
module goi_ctrl
    import goi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_func,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);
    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} t_state;

    t_state     r_state;
    t_step      r_step;
    logic [3:0] r_idx;
    logic       r_ovalid;

    t_step      n_step;
    logic [3:0] n_idx;
    logic       n_fin;
    logic       w_capture;
    logic       w_out_load;

    always_comb begin
        n_step = r_step;
        n_idx  = r_idx;
        n_fin  = 1'b0;
        unique case (r_step)
            ST_SQ_MUL: n_step = ST_SQ_ACC;
            ST_SQ_ACC: begin
                if (r_idx == 4'd2) begin
                    n_step = ST_LEN_SQRT;
                end else begin
                    n_step = ST_SQ_MUL;
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_LEN_SQRT:  n_step = ST_LEN_SAVE;
            ST_LEN_SAVE:  n_step = ST_P_MUL;
            ST_P_MUL:     n_step = ST_P_CHK;
            ST_P_CHK: begin
                if (i_stat.prod_zero) begin
                    n_fin = 1'b1;
                end else begin
                    n_step = ST_PH_MUL_H;
                end
            end
            ST_PH_MUL_H:  n_step = ST_PH_SAVE_H;
            ST_PH_SAVE_H: n_step = ST_PH_MUL_L;
            ST_PH_MUL_L:  n_step = ST_PH_SAVE_L;
            ST_PH_SAVE_L: n_step = ST_A_MUL;
            ST_A_MUL:     n_step = ST_A_SAVE;
            ST_A_SAVE:    n_step = ST_X2_MUL;
            ST_X2_MUL:    n_step = ST_X2_SAVE;
            ST_X2_SAVE: begin
                n_step = ST_H_MUL;
                n_idx  = 4'd0;
            end
            ST_H_MUL:     n_step = ST_H_DIV;
            ST_H_DIV:     n_step = ST_H_SAVE;
            ST_H_SAVE: begin
                if (r_idx == 4'd3) begin
                    n_step = ST_SN_MUL;
                end else if (r_idx == 4'd8) begin
                    n_step = ST_CS_SAVE;
                end else begin
                    n_step = ST_H_MUL;
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_SN_MUL:    n_step = ST_SN_SAVE;
            ST_SN_SAVE: begin
                n_step = ST_H_MUL;
                n_idx  = r_idx + 4'd1;
            end
            ST_CS_SAVE: begin
                n_step = ST_DV_MUL;
                n_idx  = 4'd0;
            end
            ST_DV_MUL:    n_step = ST_DV_DIV;
            ST_DV_DIV:    n_step = ST_DV_SAVE;
            ST_DV_SAVE: begin
                if (r_idx == 4'd2) begin
                    n_step = ST_QP_MUL;
                    n_idx  = 4'd0;
                end else begin
                    n_step = ST_DV_MUL;
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_QP_MUL:    n_step = ST_QP_ACC;
            ST_QP_ACC: begin
                if (r_idx[1:0] == 2'd3) begin
                    n_step = ST_QP_SAVE;
                end else begin
                    n_step = ST_QP_MUL;
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_QP_SAVE: begin
                if (r_idx == 4'd15) begin
                    n_step = ST_NQ_MUL;
                    n_idx  = 4'd0;
                end else begin
                    n_step = ST_QP_MUL;
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_NQ_MUL:    n_step = ST_NQ_ACC;
            ST_NQ_ACC: begin
                if (r_idx == 4'd3) begin
                    n_step = ST_N_SQRT;
                end else begin
                    n_step = ST_NQ_MUL;
                    n_idx  = r_idx + 4'd1;
                end
            end
            ST_N_SQRT:    n_step = ST_N_SAVE;
            ST_N_SAVE: begin
                n_idx = 4'd0;
                if (i_stat.root_zero) begin
                    n_step = ST_Q_ZERO;
                end else begin
                    n_step = ST_Q_DIV;
                end
            end
            ST_Q_DIV:     n_step = ST_Q_SAVE;
            ST_Q_SAVE: begin
                if (r_idx == 4'd3) begin
                    n_fin = 1'b1;
                end else begin
                    n_step = ST_Q_DIV;
                    n_idx  = r_idx + 4'd1;
                end
            end
            default:      n_fin = 1'b1;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign w_capture  = i_in_valid && o_in_ready;
    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_SQ_MUL;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_capture) begin
                        r_step  <= ST_SQ_MUL;
                        r_idx   <= '0;
                        r_state <= i_func ? S_OUT : S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (is_unit_step(r_step)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_step <= n_step;
                        r_idx  <= n_idx;
                        if (n_fin) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WAIT: begin
                    if (i_stat.unit_done) begin
                        r_step  <= n_step;
                        r_idx   <= n_idx;
                        r_state <= n_fin ? S_OUT : S_EXEC;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_cmd.capture  = w_capture;
    assign o_cmd.go       = (r_state == S_EXEC);
    assign o_cmd.out_load = w_out_load;
    assign o_cmd.step     = r_step;
    assign o_cmd.idx      = r_idx;
endmodule

@@ rtl/gyro_orientation_integrator.sv @@
// Top level: gyro orientation integrator, controller plus datapath.
// A load word goes straight to the output register; a gyro word runs 102 steps besides
// two square roots and seven divides; a zero angle stops after the length square root,
// and an all-zero product zeroes the orientation in place of the four final divides.
// One word in flight; the next word is taken while a result waits in the output register.
// Synchronous active-low reset: orientation to identity, time_step to 4294967.
module gyro_orientation_integrator
    import goi_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wen,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z
    input  logic [223:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [127:0] m_axis_tdata,
    // rotated
    output logic         m_axis_tuser
);
    t_cmd  w_cmd;
    t_stat w_stat;

    goi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    goi_datapath #(
        .FRAC_BITS (QUAT_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_tdata     (s_axis_tdata),
        .i_func      (s_axis_tuser),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .o_tdata     (m_axis_tdata),
        .o_rot       (m_axis_tuser)
    );
endmodule
